// File: design/iiel_pkg.sv
// Package for the indexed insert/erase list.
// Holds the operation and status codes, the default capacity and the cell control struct.
// Used by iiel_cell, indexed_insert_erase_list and the testbench; no other dependencies.
package iiel_pkg;

	localparam int unsigned DEF_CAPACITY = 16;
	localparam int unsigned DATA_W       = 32;

	typedef enum logic [2:0] {
		FN_PUSH_LAST  = 3'd0,
		FN_POP_LAST   = 3'd1,
		FN_READ_BACK  = 3'd2,
		FN_PUSH_FIRST = 3'd3,
		FN_POP_FIRST  = 3'd4,
		FN_INSERT     = 3'd5,
		FN_ERASE      = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// open: cells at and above the index move up, the cell at the index loads new data
	// close: cells at and above the index take their upper neighbor's value
	typedef struct packed {
		logic open;
		logic close;
	} shift_t;

endpackage

// File: design/indexed_insert_erase_list.sv
// Indexed insert/erase list: a row of CAPACITY cells, one entry each, plus an element count.
// An accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle while result_ready is high; every cell compares
// its index and shifts in the same cycle, and the output register is refilled in the
// cycle it is drained. Reset (arst_n low, asynchronous) empties the list and drops a
// pending result; entry storage is not cleared.
module indexed_insert_erase_list #(
	parameter int unsigned CAPACITY = iiel_pkg::DEF_CAPACITY,
	parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [2:0]                         func,
	input  logic [CW-1:0]                      position,
	input  logic signed [iiel_pkg::DATA_W-1:0] data_in,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [iiel_pkg::DATA_W-1:0] back_value,
	output logic [1:0]                         status,
	output logic [CW-1:0]                      count_after
);
	import iiel_pkg::*;

	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	logic [CW-1:0]     count_q;
	logic              result_valid_q;
	logic [DATA_W-1:0] back_value_q;
	status_t           status_q;
	logic [CW-1:0]     count_after_q;

	logic              accept;
	logic              full;
	logic              empty;
	shift_t            shift;
	logic [CW-1:0]     idx;
	logic [CW-1:0]     count_nxt;
	status_t           status_nxt;
	logic              want_back;
	logic [DATA_W-1:0] back_all;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_back [CAPACITY];

	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;
	assign full       = (count_q >= CAP);
	assign empty      = (count_q == '0);

	always_comb begin
		shift      = '0;
		idx        = '0;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		want_back  = 1'b0;
		case (func_t'(func))
			FN_PUSH_LAST: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					shift.open = 1'b1;
					idx        = count_q;
					count_nxt  = count_q + CW'(1);
				end
			end
			FN_POP_LAST: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			FN_READ_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					want_back = 1'b1;
				end
			end
			FN_PUSH_FIRST: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					shift.open = 1'b1;
					count_nxt  = count_q + CW'(1);
				end
			end
			FN_POP_FIRST: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					shift.close = 1'b1;
					count_nxt   = count_q - CW'(1);
				end
			end
			FN_INSERT: begin
				// range check wins over full check
				if (position > count_q) begin
					status_nxt = ST_RANGE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					shift.open = 1'b1;
					idx        = position;
					count_nxt  = count_q + CW'(1);
				end
			end
			FN_ERASE: begin
				if (position >= count_q) begin
					status_nxt = ST_RANGE;
				end else begin
					shift.close = 1'b1;
					idx         = position;
					count_nxt   = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			shift = '0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] lower;
		logic [DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = cell_data[0];
		end else begin : g_mid_lo
			assign lower = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = cell_data[i];
		end else begin : g_mid_hi
			assign upper = cell_data[i+1];
		end
		iiel_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.shift      (shift),
			.idx        (idx),
			.count      (count_q),
			.data_new   (data_in),
			.data_lower (lower),
			.data_upper (upper),
			.data       (cell_data[i]),
			.back       (cell_back[i])
		);
	end

	// only the cell at count-1 drives nonzero
	always_comb begin
		back_all = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_all = back_all | cell_back[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q        <= count_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			back_value_q  <= want_back ? back_all : '0;
			status_q      <= status_nxt;
			count_after_q <= count_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign back_value   = back_value_q;
	assign status       = status_q;
	assign count_after  = count_after_q;

endmodule

// File: design/iiel_cell.sv
// One storage cell of the indexed insert/erase list.
// Holds one entry and shifts with its neighbors on open/close; flags itself as the back entry.
// Depends on iiel_pkg.
module iiel_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  logic                          clk,
	input  iiel_pkg::shift_t              shift,
	input  logic [CW-1:0]                 idx,
	input  logic [CW-1:0]                 count,
	input  logic [iiel_pkg::DATA_W-1:0]   data_new,
	input  logic [iiel_pkg::DATA_W-1:0]   data_lower,
	input  logic [iiel_pkg::DATA_W-1:0]   data_upper,
	output logic [iiel_pkg::DATA_W-1:0]   data,
	output logic [iiel_pkg::DATA_W-1:0]   back
);
	import iiel_pkg::*;

	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift.open) begin
			if (MY_IDX > idx) begin
				data_q <= data_lower;
			end else if (MY_IDX == idx) begin
				data_q <= data_new;
			end
		end else if (shift.close) begin
			if (MY_IDX >= idx) begin
				data_q <= data_upper;
			end
		end
	end

	assign data = data_q;
	// masked so the top level can OR all cells together
	assign back = (count == MY_NEXT) ? data_q : '0;

endmodule

// File: test/indexed_insert_erase_list_tb.sv
// Self-checking testbench for indexed_insert_erase_list: a queue-backed list predictor
// checks every result transaction, with random valid/ready gaps on both channels.
// Depends on iiel_pkg and the indexed_insert_erase_list RTL.
module indexed_insert_erase_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iiel_pkg::*;

	localparam int unsigned CAPACITY = DEF_CAPACITY;
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
	localparam logic [2:0] FN_UNUSED = 3'd7;
	localparam int CALM_TAIL = 250;

	typedef struct {
		logic [2:0]               op;
		logic [CNT_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} list_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] back_value;
		status_t                  status;
		logic [CNT_W-1:0]         count_after;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [2:0] func = '0;
	logic [CNT_W-1:0] position = '0;
	logic signed [DATA_W-1:0] data_in = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [DATA_W-1:0] back_value;
	logic [1:0] status;
	logic [CNT_W-1:0] count_after;

	list_op_t op_q[$];
	list_result_t expected_results[$];
	logic signed [DATA_W-1:0] list_model[$];

	bit failed = 1'b0;
	bit item_taken = 1'b0;
	bit last_batch = 1'b0;
	bit calm = 1'b0;
	int send_gap = 0;
	int sink_gap = 0;
	int gen_count = 0;
	bit filling = 1'b1;

	indexed_insert_erase_list #(.CAPACITY(CAPACITY)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.func(func),
		.position(position),
		.data_in(data_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.back_value(back_value),
		.status(status),
		.count_after(count_after)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Applies one operation to the list copy and returns the result it should produce.
	function automatic list_result_t list_step(input logic [2:0] op, input logic [CNT_W-1:0] pos,
			input logic signed [DATA_W-1:0] value);
		list_result_t r;
		bit full;
		r.back_value = '0;
		r.status = ST_OK;
		full = list_model.size() >= CAPACITY;
		case (op)
		FN_PUSH_LAST: begin
			if (full) r.status = ST_FULL;
			else list_model.insert(list_model.size(), value);
		end
		FN_POP_LAST: begin
			if (list_model.size() == 0) r.status = ST_EMPTY;
			else list_model.delete(list_model.size() - 1);
		end
		FN_READ_BACK: begin
			if (list_model.size() == 0) r.status = ST_EMPTY;
			else r.back_value = list_model[list_model.size() - 1];
		end
		FN_PUSH_FIRST: begin
			if (full) r.status = ST_FULL;
			else list_model.insert(0, value);
		end
		FN_POP_FIRST: begin
			if (list_model.size() == 0) r.status = ST_EMPTY;
			else list_model.delete(0);
		end
		FN_INSERT: begin
			// range check wins over the full check
			if (int'(pos) > list_model.size()) r.status = ST_RANGE;
			else if (full) r.status = ST_FULL;
			else list_model.insert(int'(pos), value);
		end
		FN_ERASE: begin
			if (int'(pos) >= list_model.size()) r.status = ST_RANGE;
			else list_model.delete(int'(pos));
		end
		default: ;
		endcase
		r.count_after = CNT_W'(list_model.size());
		return r;
	endfunction

	// Queues one operation and tracks the list length it will leave behind.
	task automatic queue_op(input logic [2:0] op, input int pos,
			input logic signed [DATA_W-1:0] value);
		list_op_t t;
		t.op = op;
		t.pos = CNT_W'(pos);
		t.value = value;
		op_q.insert(op_q.size(), t);
		case (op)
		FN_PUSH_LAST, FN_PUSH_FIRST: if (gen_count < CAPACITY) gen_count++;
		FN_POP_LAST, FN_POP_FIRST: if (gen_count > 0) gen_count--;
		FN_INSERT: if (pos <= gen_count && gen_count < CAPACITY) gen_count++;
		FN_ERASE: if (pos < gen_count) gen_count--;
		default: ;
		endcase
	endtask

	// Alternates fill and drain phases so the list swings between empty and full.
	task automatic queue_random_ops(input int n);
		logic [2:0] op;
		int pos;
		logic signed [DATA_W-1:0] value;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			pos = $urandom_range(0, CAPACITY);
			if (r < 12) begin
				op = (r == 0) ? FN_UNUSED : 3'($urandom_range(0, 6));
			end else if (filling) begin
				case ($urandom_range(0, 9))
				0, 1, 2: op = FN_PUSH_LAST;
				3, 4: op = FN_PUSH_FIRST;
				5, 6, 7: begin
					op = FN_INSERT;
					pos = $urandom_range(0, gen_count);
				end
				8: op = FN_READ_BACK;
				default: begin
					op = FN_ERASE;
					if (gen_count > 0) pos = $urandom_range(0, gen_count - 1);
				end
				endcase
			end else begin
				case ($urandom_range(0, 9))
				0, 1: op = FN_POP_LAST;
				2, 3: op = FN_POP_FIRST;
				4, 5, 6: begin
					op = FN_ERASE;
					if (gen_count > 0) pos = $urandom_range(0, gen_count - 1);
				end
				7: op = FN_READ_BACK;
				8: op = FN_PUSH_LAST;
				default: begin
					op = FN_INSERT;
					pos = $urandom_range(0, gen_count);
				end
				endcase
			end
			case ($urandom_range(0, 11))
			0: value = 32'sh80000000;
			1: value = 32'sh7fffffff;
			2: value = '0;
			3: value = '1;
			default: value = $urandom();
			endcase
			queue_op(op, pos, value);
			if (filling && gen_count == CAPACITY && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && gen_count == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
		end
	endtask

	task automatic wait_drained();
		while (op_q.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Driver: at each falling edge, holds an untaken item or presents a new transaction or idle, and drives result_ready.
	always @(negedge clk) begin
		if (arst_n) begin
			calm = last_batch && op_q.size() < CALM_TAIL;
			if (!item_valid || item_taken) begin
				if (send_gap > 0 && !calm) begin
					item_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (op_q.size() > 0) begin
					func <= op_q[0].op;
					position <= op_q[0].pos;
					data_in <= op_q[0].value;
					item_valid <= 1'b1;
					op_q.delete(0);
					if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
				end else begin
					item_valid <= 1'b0;
				end
			end
			if (sink_gap > 0 && !calm) begin
				result_ready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				result_ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 18);
			end
		end
	end

	// Monitor: predict on accepted items, check accepted results against the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			item_taken <= item_valid && item_ready;
			if (item_valid && item_ready)
				expected_results.insert(expected_results.size(),
					list_step(func, position, data_in));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					failed = 1'b1;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (back_value !== want.back_value) begin
						$error("back_value: expected %0d, got %0d", want.back_value, back_value);
						failed = 1'b1;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						failed = 1'b1;
					end
					if (count_after !== want.count_after) begin
						$error("count_after: expected %0d, got %0d", want.count_after, count_after);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		// empty list, range and unused-opcode corner cases
		queue_op(FN_POP_LAST, 0, 32'sd5);
		queue_op(FN_READ_BACK, 0, 32'sd0);
		queue_op(FN_POP_FIRST, 0, 32'sd0);
		queue_op(FN_ERASE, 0, 32'sd0);
		queue_op(FN_INSERT, CAPACITY, 32'sd1);
		queue_op(FN_INSERT, 1, 32'sd2);
		queue_op(FN_INSERT, 0, 32'sh80000000);
		queue_op(FN_PUSH_LAST, 0, 32'sh7fffffff);
		queue_op(FN_PUSH_FIRST, 0, -32'sd1);
		queue_op(FN_READ_BACK, 0, 32'sd0);
		queue_op(FN_INSERT, 3, 32'sd0);
		queue_op(FN_INSERT, 2, 32'sh55555555);
		queue_op(FN_ERASE, 5, 32'sd0);
		queue_op(FN_ERASE, 4, 32'sd0);
		queue_op(FN_UNUSED, CAPACITY, 32'sh2468ace0);
		queue_op(FN_ERASE, 0, 32'sd0);
		queue_op(FN_READ_BACK, 0, 32'sd0);
		queue_op(FN_POP_FIRST, 0, 32'sd0);
		queue_op(FN_POP_LAST, 0, 32'sd0);
		queue_op(FN_POP_LAST, 0, 32'sd0);
		queue_op(FN_POP_LAST, 0, 32'sd0);
		queue_op(FN_PUSH_FIRST, 0, 32'shaaaaaaaa);
		queue_op(FN_ERASE, CAPACITY, 32'sd0);
		queue_op(FN_ERASE, 0, 32'sd0);
		wait_drained();
		queue_random_ops(900);
		wait_drained();
		last_batch = 1'b1;
		queue_random_ops(850);
		wait_drained();
		repeat (5) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("indexed_insert_erase_list regression: pass");
		else
			$display("indexed_insert_erase_list regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("indexed_insert_erase_list regression: fail");
		$finish;
	end

endmodule

// File: files.f
design/iiel_pkg.sv
design/iiel_cell.sv
design/indexed_insert_erase_list.sv
test/indexed_insert_erase_list_tb.sv
